// File: rtl/drpi_pkg.sv
// ----------------------------------------------------------------------------
// drpi_pkg
// Types, constants and tables shared by the dead-reckoning pose integrator.
// ----------------------------------------------------------------------------
package drpi_pkg;

    typedef struct packed {
        logic signed [15:0] linear_speed;
        logic signed [15:0] wheel_turn_rate;
        logic signed [15:0] yaw_rate;
        logic        [19:0] time_step;
    } drpi_in_t;

    typedef struct packed {
        logic signed [47:0] x_position;
        logic signed [47:0] y_position;
        logic        [31:0] heading;
        logic signed [15:0] forward_speed;
        logic signed [15:0] turn_rate_out;
    } drpi_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_SD,
        ST_YD,
        ST_PX,
        ST_PY,
        ST_PKH,
        ST_HEAD,
        ST_DONE
    } drpi_state_t;

    localparam int                 CORDIC_ITERS = 16;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    localparam logic [25:0] HEAD_K_Q28 = 26'd44798134;
    localparam logic [12:0] HEAD_K_HI  = HEAD_K_Q28[25:13];
    localparam logic [12:0] HEAD_K_LO  = HEAD_K_Q28[12:0];

    localparam logic signed [49:0] POS_MAX_EXT = 50'sd140737488355327;
    localparam logic signed [49:0] POS_MIN_EXT = -50'sd140737488355328;

    function automatic logic [29:0] atan_bam(input logic [3:0] idx);
        logic [29:0] v;
        case (idx)
            4'd0:    v = 30'h20000000;
            4'd1:    v = 30'h12E4051E;
            4'd2:    v = 30'h09FB385B;
            4'd3:    v = 30'h051111D4;
            4'd4:    v = 30'h028B0D43;
            4'd5:    v = 30'h0145D7E1;
            4'd6:    v = 30'h00A2F61E;
            4'd7:    v = 30'h00517C55;
            4'd8:    v = 30'h0028BE53;
            4'd9:    v = 30'h00145F2F;
            4'd10:   v = 30'h000A2F98;
            4'd11:   v = 30'h000517CC;
            4'd12:   v = 30'h00028BE6;
            4'd13:   v = 30'h000145F3;
            4'd14:   v = 30'h0000A2FA;
            default: v = 30'h0000517D;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/drpi_cordic.sv
// ----------------------------------------------------------------------------
// drpi_cordic
// Iterative rotation CORDIC: one micro-rotation per cycle, then quadrant
// mapping and rounding to Q1.15 cosine and sine of a binary angle.
// ----------------------------------------------------------------------------
module drpi_cordic
    import drpi_pkg::*;
#(
    parameter int TRIG_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [15:0] cos_out,
    output logic signed [15:0] sin_out
);

    localparam logic [31:0] KEEP_MASK = ~((32'd1 << (32 - TRIG_BITS)) - 32'd1);
    localparam logic [3:0]  LAST_ITER = 4'(CORDIC_ITERS - 1);

    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [31:0] z_reg, z_next;
    logic [1:0]         quad_reg;
    logic [3:0]         iter_reg;
    logic               busy_reg;
    logic               fin_reg;

    logic [31:0]        ang_masked;
    logic signed [33:0] xs, ys;
    logic signed [31:0] atan_step;
    logic signed [33:0] x_rnd, y_rnd;
    logic signed [19:0] c_raw, s_raw;
    logic signed [19:0] c_map, s_map;

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    assign ang_masked = angle & KEEP_MASK;
    assign atan_step  = $signed({2'b00, atan_bam(iter_reg)});

    always_comb begin
        xs = x_reg >>> iter_reg;
        ys = y_reg >>> iter_reg;
        if (!z_reg[31]) begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_step;
        end else begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            iter_reg <= '0;
        end else begin
            fin_reg <= busy_reg && (iter_reg == LAST_ITER);
            if (start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end else if (busy_reg) begin
                iter_reg <= iter_reg + 4'd1;
                if (iter_reg == LAST_ITER) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= CORDIC_START;
            y_reg    <= '0;
            z_reg    <= $signed({2'b00, ang_masked[29:0]});
            quad_reg <= ang_masked[31:30];
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    // round to q1.15 and fold into the quadrant
    always_comb begin
        x_rnd = (x_reg + 34'sd16384) >>> 15;
        y_rnd = (y_reg + 34'sd16384) >>> 15;
        c_raw = x_rnd[19:0];
        s_raw = y_rnd[19:0];
        case (quad_reg)
            2'd0: begin
                c_map = c_raw;
                s_map = s_raw;
            end
            2'd1: begin
                c_map = -s_raw;
                s_map = c_raw;
            end
            2'd2: begin
                c_map = -c_raw;
                s_map = -s_raw;
            end
            default: begin
                c_map = s_raw;
                s_map = -c_raw;
            end
        endcase
    end

    assign cos_out = sat16(c_map);
    assign sin_out = sat16(s_map);
    assign done    = fin_reg;

endmodule

// File: rtl/dead_reckoning_pose_integrator_core.sv
// ----------------------------------------------------------------------------
// dead_reckoning_pose_integrator_core
// Planar odometry: integrates speed and yaw rate into X, Y and heading.
// ----------------------------------------------------------------------------
// Each request's result is loaded into the output register after its steps
// run in order: the CORDIC micro-rotations and the rounding of the heading's
// cosine and sine, then six products on a single shared 36x17 multiplier
// (speed*dt, formed in the rotate state, then yaw*dt, the X and Y
// displacements and the heading scale in two halves), a heading update state
// and the load of the result register. s_ready returns as the result is
// loaded, so a new request is taken only once the last one is through.
// s_ready is high only between requests; a result waiting in the output
// register does not hold off the next request, but that request stalls
// before its load until the waiting result is taken. Positions are in
// nanometres and saturate at the 48-bit bounds, the heading is a wrapping
// binary angle. TRIG_BITS sets how many top heading bits feed the sine and
// cosine.
// ----------------------------------------------------------------------------
module dead_reckoning_pose_integrator_core
    import drpi_pkg::*;
#(
    parameter int TRIG_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  drpi_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output drpi_out_t m_data
);

    drpi_state_t state_reg, state_next;

    drpi_in_t           in_reg;
    logic signed [47:0] pos_x_reg, pos_y_reg;
    logic [31:0]        heading_reg;
    logic signed [15:0] c_reg, s_reg;
    logic signed [35:0] sd_reg, yd_reg;
    logic signed [52:0] prod_reg;
    logic signed [61:0] acc_reg;
    logic               m_valid_reg;
    drpi_out_t          m_data_reg;

    logic               accept;
    logic               trig_start;
    logic               trig_done;
    logic signed [15:0] trig_cos, trig_sin;
    logic               load_out;

    logic signed [35:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [35:0] dt_ext;

    logic signed [52:0] prod_rnd;
    logic signed [37:0] delta;
    logic signed [49:0] sum_x, sum_y;
    logic signed [47:0] pos_x_next, pos_y_next;
    logic signed [61:0] prod_ext;
    logic signed [61:0] head_sum;

    assign accept = s_valid && s_ready;

    drpi_cordic #(
        .TRIG_BITS(TRIG_BITS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (trig_start),
        .angle   (heading_reg),
        .done    (trig_done),
        .cos_out (trig_cos),
        .sin_out (trig_sin)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_ROTATE;
            ST_ROTATE: if (trig_done) state_next = ST_SD;
            ST_SD:     state_next = ST_YD;
            ST_YD:     state_next = ST_PX;
            ST_PX:     state_next = ST_PY;
            ST_PY:     state_next = ST_PKH;
            ST_PKH:    state_next = ST_HEAD;
            ST_HEAD:   state_next = ST_DONE;
            ST_DONE:   if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs and multiplier operand select
    assign dt_ext = $signed({16'd0, in_reg.time_step});

    always_comb begin
        s_ready    = 1'b0;
        trig_start = 1'b0;
        load_out   = 1'b0;
        mul_a      = dt_ext;
        mul_b      = {in_reg.linear_speed[15], in_reg.linear_speed};
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                trig_start = s_valid;
            end
            ST_ROTATE: begin
                mul_a = dt_ext;
                mul_b = {in_reg.linear_speed[15], in_reg.linear_speed};
            end
            ST_SD: begin
                mul_a = dt_ext;
                mul_b = {in_reg.yaw_rate[15], in_reg.yaw_rate};
            end
            ST_YD: begin
                mul_a = sd_reg;
                mul_b = {c_reg[15], c_reg};
            end
            ST_PX: begin
                mul_a = sd_reg;
                mul_b = {s_reg[15], s_reg};
            end
            ST_PY: begin
                mul_a = yd_reg;
                mul_b = $signed({4'd0, HEAD_K_HI});
            end
            ST_PKH: begin
                mul_a = yd_reg;
                mul_b = $signed({4'd0, HEAD_K_LO});
            end
            ST_HEAD: begin
            end
            ST_DONE: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    // displacement rounding and saturating position add
    always_comb begin
        prod_rnd = (prod_reg + 53'sd16384) >>> 15;
        delta    = prod_rnd[37:0];
        sum_x    = {{2{pos_x_reg[47]}}, pos_x_reg} + {{12{delta[37]}}, delta};
        sum_y    = {{2{pos_y_reg[47]}}, pos_y_reg} + {{12{delta[37]}}, delta};
        if (sum_x > POS_MAX_EXT) begin
            pos_x_next = POS_MAX_EXT[47:0];
        end else if (sum_x < POS_MIN_EXT) begin
            pos_x_next = POS_MIN_EXT[47:0];
        end else begin
            pos_x_next = sum_x[47:0];
        end
        if (sum_y > POS_MAX_EXT) begin
            pos_y_next = POS_MAX_EXT[47:0];
        end else if (sum_y < POS_MIN_EXT) begin
            pos_y_next = POS_MIN_EXT[47:0];
        end else begin
            pos_y_next = sum_y[47:0];
        end
    end

    assign prod_ext = {{9{prod_reg[52]}}, prod_reg};
    assign head_sum = acc_reg + prod_ext + 62'sd134217728;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_PX) begin
                pos_x_reg <= pos_x_next;
            end
            if (state_reg == ST_PY) begin
                pos_y_reg <= pos_y_next;
            end
            if (state_reg == ST_HEAD) begin
                heading_reg <= heading_reg + head_sum[59:28];
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (accept) begin
            in_reg <= s_data;
        end
        if (state_reg == ST_ROTATE && trig_done) begin
            c_reg <= trig_cos;
            s_reg <= trig_sin;
        end
        if (state_reg == ST_SD) begin
            sd_reg <= prod_reg[35:0];
        end
        if (state_reg == ST_YD) begin
            yd_reg <= prod_reg[35:0];
        end
        if (state_reg == ST_PKH) begin
            acc_reg <= prod_ext <<< 13;
        end
        if (load_out) begin
            m_data_reg.x_position    <= pos_x_reg;
            m_data_reg.y_position    <= pos_y_reg;
            m_data_reg.heading       <= heading_reg;
            m_data_reg.forward_speed <= in_reg.linear_speed;
            m_data_reg.turn_rate_out <= in_reg.wheel_turn_rate;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
